### hdl/bed_pkg.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types and character constants for the escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned MAX_RES = 5;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [7:0] ESC_CHAR = 8'h5C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_V     = 8'h76;

  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_NUL = 8'h00;
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  localparam logic [9:0] BYTE_MAX = 10'd255;

  // Pending escape depth codes.
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_ESC  = 3'd1;
  localparam logic [2:0] PEND_D    = 3'd2;
  localparam logic [2:0] PEND_DIG1 = 3'd3;
  localparam logic [2:0] PEND_DIG2 = 3'd4;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } job_t;

endpackage

### hdl/bed_front.sv
// ----------------------------------------------------------------------------
// Escape decoder front end
// Accepts raw bytes, tracks the pending escape and builds one job of up to
// five output bytes per accepted byte.
// ----------------------------------------------------------------------------
module bed_front import bed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       s_last_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [2:0] cnt_q, cnt_d, cnt_nx;
  logic [7:0] dig2_q, dig2_d, dig3_q, dig3_d;
  logic       accept;
  logic       b_dec, simp_v, emit_v, fresh;
  logic [7:0] simp_c, emit_b;
  logic [9:0] val;
  logic [2:0] fc, nc, k;
  logic [3:0][7:0] fl, nfl;

  assign s_ready_o = q_ready_i;
  assign accept    = s_valid_i && s_ready_o;
  assign b_dec     = (s_byte_i >= CH_ZERO) && (s_byte_i <= CH_NINE);
  assign val       = 10'(dig2_q[3:0]) * 10'd100 + 10'(dig3_q[3:0]) * 10'd10
                   + 10'(s_byte_i[3:0]);

  always_comb begin
    simp_v = 1'b1;
    simp_c = CODE_NUL;
    case (s_byte_i)
      CH_N:     simp_c = CODE_LF;
      CH_T:     simp_c = CODE_TAB;
      CH_R:     simp_c = CODE_CR;
      CH_ZERO:  simp_c = CODE_NUL;
      CH_A:     simp_c = CODE_BEL;
      CH_B:     simp_c = CODE_BS;
      CH_F:     simp_c = CODE_FF;
      CH_V:     simp_c = CODE_VT;
      ESC_CHAR: simp_c = ESC_CHAR;
      default:  simp_v = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    dig2_d = dig2_q;
    dig3_d = dig3_q;
    fc     = PEND_NONE;
    emit_v = 1'b0;
    emit_b = s_byte_i;
    fresh  = 1'b0;
    case (cnt_q)
      PEND_NONE: fresh = 1'b1;
      PEND_ESC: begin
        if (simp_v) begin
          emit_v = 1'b1;
          emit_b = simp_c;
          cnt_d  = PEND_NONE;
        end else if (s_byte_i == CH_D) begin
          cnt_d = PEND_D;
        end else begin
          fc    = cnt_q;
          fresh = 1'b1;
        end
      end
      PEND_D: begin
        if (b_dec) begin
          dig2_d = s_byte_i;
          cnt_d  = PEND_DIG1;
        end else begin
          fc    = cnt_q;
          fresh = 1'b1;
        end
      end
      PEND_DIG1: begin
        if (b_dec) begin
          dig3_d = s_byte_i;
          cnt_d  = PEND_DIG2;
        end else begin
          fc    = cnt_q;
          fresh = 1'b1;
        end
      end
      PEND_DIG2: begin
        if (b_dec && (val <= BYTE_MAX)) begin
          emit_v = 1'b1;
          emit_b = val[7:0];
          cnt_d  = PEND_NONE;
        end else begin
          fc    = cnt_q;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    if (fresh) begin
      if (s_byte_i == ESC_CHAR) begin
        cnt_d = PEND_ESC;
      end else begin
        emit_v = 1'b1;
        emit_b = s_byte_i;
        cnt_d  = PEND_NONE;
      end
    end
  end

  assign fl     = {dig3_q, dig2_q, CH_D, ESC_CHAR};
  assign nfl    = {dig3_d, dig2_d, CH_D, ESC_CHAR};
  assign nc     = s_last_i ? cnt_d : PEND_NONE;
  assign cnt_nx = s_last_i ? PEND_NONE : cnt_d;

  always_comb begin
    job_o.bytes = '0;
    k           = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      k = 3'(i) - fc - {2'b00, emit_v};
      if (3'(i) < fc) begin
        job_o.bytes[i] = fl[2'(i)];
      end else if (emit_v && (3'(i) == fc)) begin
        job_o.bytes[i] = emit_b;
      end else begin
        job_o.bytes[i] = nfl[k[1:0]];
      end
    end
    job_o.cnt  = fc + {2'b00, emit_v} + nc;
    job_o.last = s_last_i;
  end

  assign push_o = accept && (job_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= PEND_NONE;
    end else if (accept) begin
      cnt_q <= cnt_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dig2_q <= dig2_d;
      dig3_q <= dig3_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PEND_DIG2)
    else $error("pending count out of range");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_last_i |=> cnt_q == PEND_NONE)
    else $error("pending bytes left after last transfer");
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_last_i |-> push_o)
    else $error("last transfer produced no output");

endmodule

### hdl/bed_queue.sv
// ----------------------------------------------------------------------------
// Escape decoder job queue
// Two-entry queue of decoded jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module bed_queue import bed_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  job_t       mem_q [QDEPTH];
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'(QDEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDEPTH))
    else $error("job queue overflow");

endmodule

### hdl/bed_back.sv
// ----------------------------------------------------------------------------
// Escape decoder back end
// Walks the bytes of the head job and sends them one per cycle, while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module bed_back import bed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hvalid_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o,
  output logic       m_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q;
  logic       olast_q;
  logic       out_free, load, end_job;

  assign out_free = !ovalid_q || m_ready_i;
  assign load     = hvalid_i && out_free;
  assign end_job  = (idx_q == head_i.cnt - 3'd1);
  assign pop_o    = load && end_job;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (load) begin
      idx_d    = end_job ? 3'd0 : idx_q + 3'd1;
      ovalid_d = 1'b1;
    end else if (m_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= head_i.bytes[idx_q];
      olast_q <= head_i.last && end_job;
    end
  end

  assign m_valid_o = ovalid_q;
  assign m_byte_o  = obyte_q;
  assign m_last_o  = olast_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hvalid_i |-> idx_q < head_i.cnt)
    else $error("byte index beyond job length");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hvalid_i |-> idx_q == 3'd0)
    else $error("byte index not cleared between jobs");

endmodule

### hdl/backslash_escape_decoder.sv
// The first byte that an input transfer releases passes through the job queue and then
// the single output register of the back end before it is valid on the output.
// Output bytes leave at one per cycle while the output is not stalled; an input byte
// releases up to five bytes, and a new input byte is accepted while the job queue has
// room, so the input stalls only when the queue is full.
// Reset clears the pending escape, the job queue and the output valid.
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Decodes a byte stream with backslash escapes into raw bytes.
// ----------------------------------------------------------------------------
module backslash_escape_decoder import bed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  logic push, q_ready, pop, hvalid;
  job_t job, head;

  bed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .job_o     (job)
  );

  bed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (hvalid),
    .head_o  (head)
  );

  bed_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hvalid_i  (hvalid),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_byte_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule
